// ===== hdl/hrqp_pkg.sv =====
// Shared types and constants for the paced HID report queue.
`timescale 1ns / 1ps
`default_nettype none

package hrqp_pkg;

   localparam int REPORT_W    = 56;
   localparam int KEYS_W      = 48;
   localparam int REPORT_KEYS = 6;
   localparam int MAX_SLOTS   = 8;
   localparam int LEVEL_W     = 5;

   localparam logic [6:0]  KEY_CODE_MASK = 7'h7F;
   localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;
   localparam logic [15:0] INTERVAL_RST  = 16'd8;

   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [1:0] {
      ST_NONE    = 2'd0,
      ST_QUEUED  = 2'd1,
      ST_FLUSHED = 2'd2,
      ST_DROPPED = 2'd3
   } status_type;

   // classified word handed from the front end to the back end
   typedef struct packed {
      logic                link_up;
      logic                op;
      logic                changed;
      logic [REPORT_W-1:0] report;
   } cmd_type;

endpackage

`default_nettype wire

// ===== hdl/hid_report_queue_pacer.sv =====
// Top level of the paced HID boot keyboard report queue.
`timescale 1ns / 1ps
`default_nettype none

// Takes key scans and millisecond ticks on req_ and returns exactly one rsp_
// word per req_ word, in order. The front end packs the scan into a report
// and compares it with the previous scan in the cycle it is accepted; a
// two-entry queue carries it to the back end, which updates the report store,
// applies the send interval and loads the result register. One word per
// clock is sustained while rsp_ready stays high; rsp_valid follows the req_
// accept through the command queue and then the result register, which the
// back end loads together with the registered read of the report store. csr_
// writes set the minimum interval in milliseconds (0 acts as 1, reset value 8)
// and are always ready.

module hid_report_queue_pacer #(
   parameter int QUEUE_DEPTH = 16,
   parameter int SCAN_SLOTS  = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_op,
   input  wire logic                          req_link_up,
   input  wire logic [7:0]                    req_modifiers,
   input  wire logic [7:0]                    req_key_slot_0,
   input  wire logic [7:0]                    req_key_slot_1,
   input  wire logic [7:0]                    req_key_slot_2,
   input  wire logic [7:0]                    req_key_slot_3,
   input  wire logic [7:0]                    req_key_slot_4,
   input  wire logic [7:0]                    req_key_slot_5,
   input  wire logic [7:0]                    req_key_slot_6,
   input  wire logic [7:0]                    req_key_slot_7,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [15:0]                   csr_wdata,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_report_valid,
   output logic [7:0]                         rsp_report_modifiers,
   output logic [hrqp_pkg::KEYS_W-1:0]        rsp_report_keys,
   output logic [1:0]                         rsp_enqueue_status,
   output logic [hrqp_pkg::LEVEL_W-1:0]       rsp_queue_level
);
   import hrqp_pkg::*;

   logic [MAX_SLOTS-1:0][7:0] key_slots;
   cmd_type                   push_cmd, pop_cmd;
   logic                      push_valid, push_ready;
   logic                      pop_valid, pop_ready;

   assign key_slots = {req_key_slot_7, req_key_slot_6, req_key_slot_5, req_key_slot_4,
                       req_key_slot_3, req_key_slot_2, req_key_slot_1, req_key_slot_0};

   hrqp_front #(
      .SCAN_SLOTS (SCAN_SLOTS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_link_up   (req_link_up),
      .req_modifiers (req_modifiers),
      .req_key_slots (key_slots),
      .push_cmd      (push_cmd),
      .push_valid    (push_valid),
      .push_ready    (push_ready)
   );

   hrqp_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_cmd    (pop_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   hrqp_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .pop_cmd              (pop_cmd),
      .pop_valid            (pop_valid),
      .pop_ready            (pop_ready),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_wdata            (csr_wdata),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_report_valid     (rsp_report_valid),
      .rsp_report_modifiers (rsp_report_modifiers),
      .rsp_report_keys      (rsp_report_keys),
      .rsp_enqueue_status   (rsp_enqueue_status),
      .rsp_queue_level      (rsp_queue_level)
   );

endmodule

`default_nettype wire

// ===== hdl/hrqp_front.sv =====
// Front end: packs a scan into a report and flags whether it changed.
`timescale 1ns / 1ps
`default_nettype none

module hrqp_front #(
   parameter int SCAN_SLOTS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_op,
   input  wire logic                                 req_link_up,
   input  wire logic [7:0]                           req_modifiers,
   input  wire logic [hrqp_pkg::MAX_SLOTS-1:0][7:0]  req_key_slots,
   output hrqp_pkg::cmd_type                         push_cmd,
   output logic                                      push_valid,
   input  wire logic                                 push_ready
);
   import hrqp_pkg::*;

   logic [REPORT_W-1:0] prev_ff, prev_in;
   logic [REPORT_W-1:0] report;
   logic [2:0]          n_keys;
   logic                accept;

   // nonzero slots go in slot order into the six key bytes; bit 7 is dropped
   always_comb begin
      report          = '0;
      n_keys          = '0;
      report[55:48]   = req_modifiers;
      for (int s = 0; s < SCAN_SLOTS; s++) begin
         if (req_key_slots[s] != 8'd0 && n_keys < 3'(REPORT_KEYS)) begin
            report[8*n_keys +: 8] = {1'b0, req_key_slots[s][6:0] & KEY_CODE_MASK};
            n_keys                = n_keys + 3'd1;
         end
      end
   end

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   always_comb begin
      push_cmd.link_up = req_link_up;
      push_cmd.op      = req_op;
      push_cmd.changed = (report != prev_ff);
      push_cmd.report  = report;
   end

   always_comb begin
      prev_in = prev_ff;
      if (accept) begin
         if (!req_link_up) begin
            prev_in = '0;
         end else if (req_op == OP_SCAN) begin
            prev_in = report;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/hrqp_cmd_fifo.sv =====
// Two-entry queue of classified words between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module hrqp_cmd_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire hrqp_pkg::cmd_type  push_cmd,
   input  wire logic               push_valid,
   output logic                    push_ready,
   output hrqp_pkg::cmd_type       pop_cmd,
   output logic                    pop_valid,
   input  wire logic               pop_ready
);
   import hrqp_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/hrqp_back.sv =====
// Back end: report queue, send pacing, interval register and result register.
`timescale 1ns / 1ps
`default_nettype none

module hrqp_back #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire hrqp_pkg::cmd_type                 pop_cmd,
   input  wire logic                              pop_valid,
   output logic                                   pop_ready,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [15:0]                       csr_wdata,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_report_valid,
   output logic [7:0]                             rsp_report_modifiers,
   output logic [hrqp_pkg::KEYS_W-1:0]            rsp_report_keys,
   output logic [1:0]                             rsp_enqueue_status,
   output logic [hrqp_pkg::LEVEL_W-1:0]           rsp_queue_level
);
   import hrqp_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

   logic [REPORT_W-1:0] report_store_ff [QUEUE_DEPTH];

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   elapsed_ff, elapsed_in;
   logic          sent_before_ff, sent_before_in;
   logic [15:0]   interval_ff;
   logic [15:0]   interval_eff;

   logic                rsp_valid_ff;
   logic                sent_ff;
   status_type          status_ff, status;
   logic [CW-1:0]       level_ff;
   logic                byp_ff;
   logic [REPORT_W-1:0] byp_rep_ff;
   logic [REPORT_W-1:0] rd_data_ff;

   logic                fire;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [REPORT_W-1:0] wr_data;
   logic                send;
   logic                byp;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [REPORT_W-1:0] sent_word;
   logic [CW+4:0]       level_ext;

   assign csr_ready = 1'b1;
   assign fire      = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign interval_eff = (interval_ff == 16'd0) ? 16'd1 : interval_ff;

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      elapsed_in     = elapsed_ff;
      sent_before_in = sent_before_ff;
      status         = ST_NONE;
      wr_en          = 1'b0;
      wr_addr        = tail_ff;
      wr_data        = pop_cmd.report;
      send           = 1'b0;
      byp            = 1'b0;
      rd_addr        = head_ff;

      if (!pop_cmd.link_up) begin
         head_in        = '0;
         tail_in        = '0;
         count_in       = '0;
         elapsed_in     = '0;
         sent_before_in = 1'b0;
      end else begin
         if (pop_cmd.op == OP_SCAN) begin
            if (pop_cmd.changed) begin
               if (count_ff == FULL_CNT) begin
                  if (pop_cmd.report == '0) begin
                     // all keys released: flush and keep only the release
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     head_in  = '0;
                     tail_in  = AW'(1);
                     count_in = CW'(1);
                     status   = ST_FLUSHED;
                  end else begin
                     status = ST_DROPPED;
                  end
               end else begin
                  wr_en    = 1'b1;
                  tail_in  = (tail_ff == LAST_IDX) ? '0 : tail_ff + AW'(1);
                  count_in = count_ff + CW'(1);
                  status   = ST_QUEUED;
               end
            end
         end else if (elapsed_ff != ELAPSED_MAX) begin
            elapsed_in = elapsed_ff + 16'd1;
         end

         if (count_in != '0 && (!sent_before_in || elapsed_in >= interval_eff)) begin
            send    = 1'b1;
            // a lone entry written now is the head; take it straight from the word
            byp     = wr_en && (count_in == CW'(1));
            rd_addr = head_in;
            head_in = (head_in == LAST_IDX) ? '0 : head_in + AW'(1);
            count_in       = count_in - CW'(1);
            elapsed_in     = '0;
            sent_before_in = 1'b1;
         end
      end
   end

   assign rd_en = fire && send && !byp;

   always_ff @(posedge clock) begin
      if (fire && wr_en) begin
         report_store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= report_store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         elapsed_ff     <= '0;
         sent_before_ff <= 1'b0;
         interval_ff    <= INTERVAL_RST;
         rsp_valid_ff   <= 1'b0;
         sent_ff        <= 1'b0;
         status_ff      <= ST_NONE;
         level_ff       <= '0;
         byp_ff         <= 1'b0;
      end else begin
         if (csr_valid) begin
            interval_ff <= csr_wdata;
         end
         if (fire) begin
            head_ff        <= head_in;
            tail_ff        <= tail_in;
            count_ff       <= count_in;
            elapsed_ff     <= elapsed_in;
            sent_before_ff <= sent_before_in;
            rsp_valid_ff   <= 1'b1;
            sent_ff        <= send;
            status_ff      <= status;
            level_ff       <= count_in;
            byp_ff         <= byp;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && byp) begin
         byp_rep_ff <= pop_cmd.report;
      end
   end

   assign sent_word = byp_ff ? byp_rep_ff : rd_data_ff;
   assign level_ext = {5'd0, level_ff};

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_report_valid     = sent_ff;
   assign rsp_report_modifiers = sent_ff ? sent_word[55:48] : 8'd0;
   assign rsp_report_keys      = sent_ff ? sent_word[KEYS_W-1:0] : '0;
   assign rsp_enqueue_status   = status_ff;
   assign rsp_queue_level      = level_ext[LEVEL_W-1:0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("report queue count above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> head_ff == tail_ff)
      else $error("empty queue with head and tail apart");

   a_link_down_clears: assert property (@(posedge clock) disable iff (reset)
      fire && !pop_cmd.link_up |=> count_ff == '0 && !sent_before_ff)
      else $error("link down did not clear queue and pacing");

   a_send_restarts: assert property (@(posedge clock) disable iff (reset)
      fire && send |=> elapsed_ff == '0 && sent_before_ff && sent_ff)
      else $error("send did not restart the interval");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the paced HID keyboard report queue.
`timescale 1ns / 1ps

module tb_top;
   import hrqp_pkg::*;

   localparam int QDEPTH = 16;
   localparam int SLOTS  = 8;

   typedef struct packed {
      logic               valid;
      logic [7:0]         mods;
      logic [KEYS_W-1:0]  keys;
      status_type         status;
      logic [LEVEL_W-1:0] level;
   } hid_reply_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_op = OP_SCAN;
   logic              req_link_up = 1'b0;
   logic [7:0]        req_modifiers = 8'h00;
   logic [7:0]        req_key_slot_0 = 8'h00;
   logic [7:0]        req_key_slot_1 = 8'h00;
   logic [7:0]        req_key_slot_2 = 8'h00;
   logic [7:0]        req_key_slot_3 = 8'h00;
   logic [7:0]        req_key_slot_4 = 8'h00;
   logic [7:0]        req_key_slot_5 = 8'h00;
   logic [7:0]        req_key_slot_6 = 8'h00;
   logic [7:0]        req_key_slot_7 = 8'h00;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [15:0]       csr_wdata = 16'h0000;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_report_valid;
   logic [7:0]        rsp_report_modifiers;
   logic [KEYS_W-1:0] rsp_report_keys;
   logic [1:0]        rsp_enqueue_status;
   logic [LEVEL_W-1:0] rsp_queue_level;

   // predictor state
   logic [REPORT_W-1:0] report_fifo [QDEPTH];
   int                  fifo_head;
   int                  fifo_tail;
   int                  fifo_held;
   logic [REPORT_W-1:0] last_scan;
   logic [15:0]         ms_since_send;
   logic                sent_any;
   logic [15:0]         interval_cfg;

   hid_reply_type awaited_replies [$];
   hid_reply_type seen;
   hid_reply_type want;

   bit          idling = 1'b1;
   int unsigned stall_draw;
   int unsigned stall_left;
   logic [7:0]  recent_mods = 8'h00;
   logic [63:0] recent_slots = '0;

   int mismatches = 0;
   int words_sent = 0;
   int replies_checked = 0;
   int reports_sent = 0;
   int flush_count = 0;
   int drop_count = 0;
   int setting_count = 0;

   hid_report_queue_pacer #(
      .QUEUE_DEPTH(QDEPTH),
      .SCAN_SLOTS(SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_link_up(req_link_up),
      .req_modifiers(req_modifiers),
      .req_key_slot_0(req_key_slot_0),
      .req_key_slot_1(req_key_slot_1),
      .req_key_slot_2(req_key_slot_2),
      .req_key_slot_3(req_key_slot_3),
      .req_key_slot_4(req_key_slot_4),
      .req_key_slot_5(req_key_slot_5),
      .req_key_slot_6(req_key_slot_6),
      .req_key_slot_7(req_key_slot_7),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_report_valid(rsp_report_valid),
      .rsp_report_modifiers(rsp_report_modifiers),
      .rsp_report_keys(rsp_report_keys),
      .rsp_enqueue_status(rsp_enqueue_status),
      .rsp_queue_level(rsp_queue_level)
   );

   always #5 clock = ~clock;

   function automatic void clear_link_state();
      fifo_head     = 0;
      fifo_tail     = 0;
      fifo_held     = 0;
      last_scan     = '0;
      ms_since_send = '0;
      sent_any      = 1'b0;
   endfunction

   // Expected reply for one request word; advances the predictor state.
   function automatic hid_reply_type compute_report_reply(logic op, logic link,
                                                          logic [7:0] mods,
                                                          logic [63:0] slots);
      hid_reply_type   r;
      logic [REPORT_W-1:0] rep;
      logic [15:0]     limit;
      int              n;
      int              s;
      r = '0;
      r.status = ST_NONE;
      if (!link) begin
         clear_link_state();
      end else begin
         if (op == OP_SCAN) begin
            rep = {mods, 48'd0};
            n = 0;
            for (s = 0; s < SLOTS; s++) begin
               if (slots[8*s +: 8] != 8'h00 && n < REPORT_KEYS) begin
                  rep[8*n +: 8] = {1'b0, slots[8*s +: 7] & KEY_CODE_MASK};
                  n++;
               end
            end
            if (rep != last_scan) begin
               if (fifo_held >= QDEPTH) begin
                  if (rep == '0) begin
                     // release on a full queue: flush and keep only it
                     report_fifo[0] = '0;
                     fifo_head = 0;
                     fifo_tail = 1 % QDEPTH;
                     fifo_held = 1;
                     r.status = ST_FLUSHED;
                     flush_count++;
                  end else begin
                     r.status = ST_DROPPED;
                     drop_count++;
                  end
               end else begin
                  report_fifo[fifo_tail] = rep;
                  fifo_tail = (fifo_tail + 1) % QDEPTH;
                  fifo_held++;
                  r.status = ST_QUEUED;
               end
               last_scan = rep;
            end
         end else if (ms_since_send != ELAPSED_MAX) begin
            ms_since_send++;
         end
         limit = (interval_cfg == 16'd0) ? 16'd1 : interval_cfg;
         if (fifo_held > 0 && (!sent_any || ms_since_send >= limit)) begin
            r.valid = 1'b1;
            r.mods  = report_fifo[fifo_head][55:48];
            r.keys  = report_fifo[fifo_head][47:0];
            fifo_head = (fifo_head + 1) % QDEPTH;
            fifo_held--;
            ms_since_send = '0;
            sent_any = 1'b1;
            reports_sent++;
         end
      end
      r.level = fifo_held[LEVEL_W-1:0];
      return r;
   endfunction

   function automatic logic [63:0] random_slots();
      logic [63:0] v;
      int          s;
      v = '0;
      for (s = 0; s < 8; s++) begin
         if ($urandom_range(0, 1) == 1)
            v[8*s +: 8] = ($urandom_range(0, 7) == 0) ? 8'h80 : 8'($urandom_range(1, 255));
      end
      return v;
   endfunction

   // Drives one request word and records the reply it should produce.
   task automatic send_word(logic op, logic link, logic [7:0] mods, logic [63:0] slots);
      int gap;
      gap = idling ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_link_up    <= link;
      req_modifiers  <= mods;
      req_key_slot_0 <= slots[7:0];
      req_key_slot_1 <= slots[15:8];
      req_key_slot_2 <= slots[23:16];
      req_key_slot_3 <= slots[31:24];
      req_key_slot_4 <= slots[39:32];
      req_key_slot_5 <= slots[47:40];
      req_key_slot_6 <= slots[55:48];
      req_key_slot_7 <= slots[63:56];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      awaited_replies.push_back(compute_report_reply(op, link, mods, slots));
      words_sent++;
      if (op == OP_SCAN) begin
         recent_mods  = mods;
         recent_slots = slots;
      end
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_interval(logic [15:0] value);
      wait_for_idle();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      interval_cfg = value;
      setting_count++;
   endtask

   // Reset interval: immediate first send, packing limits, pacing, link drop.
   task automatic test_directed_basics();
      int n;
      send_word(OP_TICK, 1'b1, 8'h00, '0);
      send_word(OP_SCAN, 1'b1, 8'hFF, {8{8'hFF}});
      send_word(OP_SCAN, 1'b1, 8'hFF, {8{8'hFF}});
      // key with only bit 7 set still takes a slot
      send_word(OP_SCAN, 1'b1, 8'h00, 64'h0000_0000_0100_0080);
      send_word(OP_SCAN, 1'b1, 8'h00, '0);
      for (n = 0; n < 16; n++)
         send_word(OP_TICK, 1'b1, 8'h00, '0);
      send_word(OP_SCAN, 1'b1, 8'h02, 64'h0000_0000_0000_0004);
      send_word(OP_SCAN, 1'b0, 8'h12, 64'h0000_0000_0000_0005);
      send_word(OP_TICK, 1'b0, 8'h00, '0);
      send_word(OP_SCAN, 1'b1, 8'h01, 64'h2A00_0000_0000_0000);
   endtask

   task automatic test_interval_zero();
      write_interval(16'd0);
      send_word(OP_SCAN, 1'b1, 8'h00, 64'h0000_0000_0000_0004);
      send_word(OP_TICK, 1'b1, 8'h00, '0);
      send_word(OP_SCAN, 1'b1, 8'h20, 64'h0000_0000_0000_0004);
      send_word(OP_SCAN, 1'b1, 8'h20, 64'h0000_0000_0007_0004);
      send_word(OP_TICK, 1'b1, 8'h00, '0);
      send_word(OP_TICK, 1'b1, 8'h00, '0);
   endtask

   // Longest interval: after the first send, ticks bring no send and later reports stay queued.
   task automatic test_long_interval();
      int n;
      write_interval(16'hFFFF);
      idling = 1'b0;
      send_word(OP_TICK, 1'b0, 8'h00, '0);
      send_word(OP_SCAN, 1'b1, 8'h00, 64'h0000_0000_0000_0009);
      for (n = 0; n < 64; n++)
         send_word(OP_TICK, 1'b1, 8'h00, '0);
      send_word(OP_SCAN, 1'b1, 8'h00, 64'h0000_0000_0000_000A);
      send_word(OP_SCAN, 1'b1, 8'h00, 64'h0000_0000_0000_000B);
      idling = 1'b1;
   endtask

   task automatic test_random_traffic();
      int          phase;
      int          i;
      int          pick;
      int          tick_pct;
      logic [7:0]  mods;
      logic [63:0] slots;
      for (phase = 0; phase < 16; phase++) begin
         case (phase)
            0: write_interval(16'd1);
            1: write_interval(16'hFFFF);
            2: write_interval(16'd0);
            default: begin
               case ($urandom_range(0, 3))
                  0: write_interval(16'($urandom_range(1, 4)));
                  1: write_interval(16'($urandom_range(5, 24)));
                  2: write_interval(16'($urandom_range(25, 400)));
                  default: write_interval(16'($urandom));
               endcase
            end
         endcase
         idling   = (phase % 4 != 3);
         tick_pct = $urandom_range(5, 60);
         for (i = 0; i < 100; i++) begin
            pick  = $urandom_range(0, 99);
            mods  = 8'($urandom);
            slots = {$urandom, $urandom};
            if (pick < 3) begin
               send_word(1'($urandom_range(0, 1)), 1'b0, mods, slots);
            end else if (pick < 3 + tick_pct) begin
               send_word(OP_TICK, 1'b1, mods, slots);
            end else begin
               pick = $urandom_range(0, 19);
               if (pick < 3) begin
                  mods  = recent_mods;
                  slots = recent_slots;
               end else if (pick < 5) begin
                  mods  = 8'h00;
                  slots = '0;
               end else begin
                  slots = random_slots();
               end
               send_word(OP_SCAN, 1'b1, mods, slots);
            end
         end
      end
      idling = 1'b1;
   endtask

   // Reply side back-pressure: after each word taken, ready drops for a randomly drawn stall while idling is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_ready) begin
         if (rsp_valid) begin
            stall_draw = idling ? $urandom_range(0, 9) : 0;
            if (stall_draw != 0) begin
               rsp_ready  <= 1'b0;
               stall_left <= stall_draw - 1;
            end
         end
      end else if (stall_left == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_report_valid, rsp_report_modifiers, rsp_report_keys,
                 rsp_enqueue_status, rsp_queue_level};
         replies_checked++;
         if (awaited_replies.size() == 0) begin
            if (mismatches < 10)
               $display("ERROR %0t: reply word with nothing pending", $realtime);
            mismatches++;
         end else begin
            want = awaited_replies.pop_front();
            if (seen.valid !== want.valid || seen.mods !== want.mods ||
                seen.keys !== want.keys || seen.status !== want.status ||
                seen.level !== want.level) begin
               if (mismatches < 10) begin
                  $display("ERROR %0t: reply %0d", $realtime, replies_checked);
                  $display("  expected valid=%0b mods=%02h keys=%012h status=%0d level=%0d",
                           want.valid, want.mods, want.keys, want.status, want.level);
                  $display("  actual   valid=%0b mods=%02h keys=%012h status=%0d level=%0d",
                           seen.valid, seen.mods, seen.keys, seen.status, seen.level);
               end
               mismatches++;
            end
         end
      end
   end

   initial begin
      for (int k = 0; k < QDEPTH; k++)
         report_fifo[k] = '0;
      clear_link_state();
      interval_cfg = INTERVAL_RST;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_interval_zero();
      test_long_interval();
      test_random_traffic();
      wait_for_idle();
      repeat (16) @(posedge clock);
      $display("Covered %0d request words over %0d interval settings.",
               words_sent, setting_count);
      $display("Checked %0d replies: %0d reports sent, %0d flushes, %0d drops.",
               replies_checked, reports_sent, flush_count, drop_count);
      if (mismatches == 0 && awaited_replies.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("ERROR: run timed out with %0d replies pending", awaited_replies.size());
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== hid_report_queue_pacer.f =====
hdl/hrqp_pkg.sv
hdl/hrqp_front.sv
hdl/hrqp_cmd_fifo.sv
hdl/hrqp_back.sv
hdl/hid_report_queue_pacer.sv
tb/sv/tb_top.sv
